// ----- hw/rtl/crp_pkg.sv -----
// shared types, constants and tables for the cartesian to polar radar block
`default_nettype none
package crp_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int CORDIC_IDX_W  = $clog2(CORDIC_STAGES);
  localparam int SQRT_STAGES   = 32;
  localparam int DIV_STAGES    = 33;
  // bearing waits until the divider chain is done
  localparam int BRG_DELAY     = SQRT_STAGES + DIV_STAGES + 2 - CORDIC_STAGES;

  localparam logic [7:0] REG_MIN_ABS_POS_X      = 8'd0;
  localparam logic [7:0] REG_MIN_RADIUS_SQUARED = 8'd1;

  localparam logic [15:0] MIN_ABS_POS_X_RST      = 16'd7;
  localparam logic [31:0] MIN_RADIUS_SQUARED_RST = 32'd429497;

  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [17:0] BEARING_MAX = 18'sd25736;

  localparam logic [29:0] ATAN_Q30 [32] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
    30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
    30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
  };

  typedef struct packed {
    logic valid;
    logic guard;
    logic neg;
  } side_t;

  typedef struct packed {
    side_t        side;
    logic [63:0]  rad;
    logic [33:0]  rem;
    logic [31:0]  root;
    logic [63:0]  mag;
  } sqrt_t;

  typedef struct packed {
    side_t        side;
    logic         ovf;
    logic [31:0]  divisor;
    logic [31:0]  rem;
    logic [32:0]  dvd;
    logic [32:0]  quo;
  } div_t;

  typedef struct packed {
    logic signed [35:0] x;
    logic signed [35:0] y;
    logic signed [34:0] z;
  } cordic_t;

endpackage
`default_nettype wire

// ----- hw/rtl/crp_sqrt_cell.sv -----
// one digit cell of the pipelined integer square root
`default_nettype none
module crp_sqrt_cell
  import crp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  adv,
  input  wire sqrt_t d,
  output sqrt_t      q
);

  sqrt_t       q_r;
  sqrt_t       q_nxt;
  logic [35:0] rem_sh;
  logic [35:0] trial;

  always_comb begin
    rem_sh = {d.rem, d.rad[63:62]};
    trial  = {2'b00, d.root, 2'b01};
    q_nxt      = d;
    q_nxt.rad  = {d.rad[61:0], 2'b00};
    if (rem_sh >= trial) begin
      q_nxt.rem  = 34'(rem_sh - trial);
      q_nxt.root = {d.root[30:0], 1'b1};
    end else begin
      q_nxt.rem  = rem_sh[33:0];
      q_nxt.root = {d.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.side.valid <= 1'b0;
    end else if (adv) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule
`default_nettype wire

// ----- hw/rtl/crp_div_cell.sv -----
// one quotient bit cell of the pipelined restoring divider
`default_nettype none
module crp_div_cell
  import crp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic adv,
  input  wire div_t d,
  output div_t      q
);

  div_t        q_r;
  div_t        q_nxt;
  logic [32:0] rem_sh;

  always_comb begin
    rem_sh    = {d.rem, d.dvd[32]};
    q_nxt     = d;
    q_nxt.dvd = {d.dvd[31:0], 1'b0};
    if (rem_sh >= {1'b0, d.divisor}) begin
      q_nxt.rem = 32'(rem_sh - {1'b0, d.divisor});
      q_nxt.quo = {d.quo[31:0], 1'b1};
    end else begin
      q_nxt.rem = rem_sh[31:0];
      q_nxt.quo = {d.quo[31:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.side.valid <= 1'b0;
    end else if (adv) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule
`default_nettype wire

// ----- hw/rtl/crp_cordic_cell.sv -----
// one micro-rotation cell of the vectoring cordic
`default_nettype none
module crp_cordic_cell
  import crp_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    adv,
  input  wire logic [CORDIC_IDX_W-1:0] idx,
  input  wire cordic_t                 d,
  output cordic_t                      q
);

  cordic_t            q_r;
  cordic_t            q_nxt;
  logic signed [35:0] x;
  logic signed [35:0] y;
  logic signed [35:0] xs;
  logic signed [35:0] ys;
  logic signed [34:0] ang;

  always_comb begin
    x   = d.x;
    y   = d.y;
    xs  = x >>> idx;
    ys  = y >>> idx;
    ang = $signed({5'b00000, ATAN_Q30[5'(idx)]});
    if (!y[35]) begin
      q_nxt.x = x + ys;
      q_nxt.y = y - xs;
      q_nxt.z = d.z + ang;
    end else begin
      q_nxt.x = x - ys;
      q_nxt.y = y + xs;
      q_nxt.z = d.z - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule
`default_nettype wire

// ----- hw/rtl/cartesian_to_radar_polar.sv -----
// top level: cartesian track state to radar range, bearing and range rate
`default_nettype none
// Takes one tracked state per cycle and returns range, bearing and range rate
// one item per cycle, both only while the pipeline is not stalled.
// The path runs through the 32-cell square root chain followed by the 33-cell
// divider chain; the cordic chain runs alongside the root and its bearing is
// delayed to meet the quotient. The whole pipeline moves in lockstep: it
// advances whenever the output register is empty or its item is being taken,
// so in_stall is high exactly while a finished item waits under out_stall.
// Guard thresholds are written on the cfg port (index 0: min |x|, index 1:
// min x^2+y^2); other indexes are ignored, cfg_ready is always high, and
// writes must only happen while the pipeline holds no items.
module cartesian_to_radar_polar
  import crp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_vel_x,
  input  wire logic signed [31:0] in_vel_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [31:0]             out_range_out,
  output logic signed [15:0]      out_bearing,
  output logic signed [31:0]      out_range_rate,
  output logic                    out_guard_hit,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [7:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  // global advance for every stage
  logic adv;

  // configuration registers
  logic [15:0] min_abs_pos_x_r;
  logic [31:0] min_radius_squared_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_abs_pos_x_r      <= MIN_ABS_POS_X_RST;
      min_radius_squared_r <= MIN_RADIUS_SQUARED_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_MIN_ABS_POS_X) begin
        min_abs_pos_x_r <= cfg_data[15:0];
      end
      if (cfg_index == REG_MIN_RADIUS_SQUARED) begin
        min_radius_squared_r <= cfg_data;
      end
    end
  end

  // stage a: magnitudes and signs
  logic               a_valid_r;
  logic signed [31:0] a_px_r;
  logic signed [31:0] a_py_r;
  logic [31:0]        a_apx_r, a_apy_r, a_avx_r, a_avy_r;
  logic               a_n1_r, a_n2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_px_r  <= in_pos_x;
      a_py_r  <= in_pos_y;
      a_apx_r <= in_pos_x[31] ? 32'd0 - $unsigned(in_pos_x) : $unsigned(in_pos_x);
      a_apy_r <= in_pos_y[31] ? 32'd0 - $unsigned(in_pos_y) : $unsigned(in_pos_y);
      a_avx_r <= in_vel_x[31] ? 32'd0 - $unsigned(in_vel_x) : $unsigned(in_vel_x);
      a_avy_r <= in_vel_y[31] ? 32'd0 - $unsigned(in_vel_y) : $unsigned(in_vel_y);
      a_n1_r  <= in_pos_x[31] ^ in_vel_x[31];
      a_n2_r  <= in_pos_y[31] ^ in_vel_y[31];
    end
  end

  // stage b: four products and cordic start vector
  logic        b_valid_r;
  logic [63:0] b_sqx_r, b_sqy_r, b_m1_r, b_m2_r;
  logic [31:0] b_apx_r;
  logic        b_n1_r, b_n2_r;
  cordic_t     cor_init_nxt;
  cordic_t     cordic_chain [CORDIC_STAGES+1];

  always_comb begin
    if (a_px_r[31]) begin
      // left half plane: turn by pi first
      cor_init_nxt.x = -36'(a_px_r);
      cor_init_nxt.y = -36'(a_py_r);
      cor_init_nxt.z = a_py_r[31] ? -PI_Q30 : PI_Q30;
    end else begin
      cor_init_nxt.x = 36'(a_px_r);
      cor_init_nxt.y = 36'(a_py_r);
      cor_init_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_sqx_r         <= a_apx_r * a_apx_r;
      b_sqy_r         <= a_apy_r * a_apy_r;
      b_m1_r          <= a_apx_r * a_avx_r;
      b_m2_r          <= a_apy_r * a_avy_r;
      b_apx_r         <= a_apx_r;
      b_n1_r          <= a_n1_r;
      b_n2_r          <= a_n2_r;
      cordic_chain[0] <= cor_init_nxt;
    end
  end

  // stage c: radius squared, guard, signed dot product
  logic [63:0] r2_nxt;
  logic [63:0] mag_nxt;
  logic        neg_nxt;
  logic        guard_nxt;
  sqrt_t       sqrt_chain [SQRT_STAGES+1];

  always_comb begin
    r2_nxt    = b_sqx_r + b_sqy_r;
    guard_nxt = (b_apx_r < {16'd0, min_abs_pos_x_r}) ||
                (r2_nxt < {32'd0, min_radius_squared_r});
    if (b_n1_r == b_n2_r) begin
      mag_nxt = b_m1_r + b_m2_r;
      neg_nxt = b_n1_r;
    end else if (b_m1_r >= b_m2_r) begin
      mag_nxt = b_m1_r - b_m2_r;
      neg_nxt = b_n1_r;
    end else begin
      mag_nxt = b_m2_r - b_m1_r;
      neg_nxt = b_n2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqrt_chain[0].side.valid <= 1'b0;
    end else if (adv) begin
      sqrt_chain[0].side.valid <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqrt_chain[0].side.guard <= guard_nxt;
      sqrt_chain[0].side.neg   <= neg_nxt;
      sqrt_chain[0].rad        <= r2_nxt;
      sqrt_chain[0].rem        <= '0;
      sqrt_chain[0].root       <= '0;
      sqrt_chain[0].mag        <= mag_nxt;
    end
  end

  // square root chain, two radicand bits per cell
  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    crp_sqrt_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .adv  (adv),
      .d    (sqrt_chain[k]),
      .q    (sqrt_chain[k+1])
    );
  end

  // divider entry: overflow check and initial remainder
  sqrt_t sq_end;
  div_t  div_chain [DIV_STAGES+1];

  assign sq_end = sqrt_chain[SQRT_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_chain[0].side.valid <= 1'b0;
    end else if (adv) begin
      div_chain[0].side.valid <= sq_end.side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_chain[0].side.guard <= sq_end.side.guard;
      div_chain[0].side.neg   <= sq_end.side.neg;
      // quotient of 2^33 or more flags overflow and saturates unless the divisor is zero
      div_chain[0].ovf        <= {1'b0, sq_end.mag[63:33]} >= sq_end.root;
      div_chain[0].divisor    <= sq_end.root;
      div_chain[0].rem        <= {1'b0, sq_end.mag[63:33]};
      div_chain[0].dvd        <= sq_end.mag[32:0];
      div_chain[0].quo        <= '0;
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    crp_div_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .adv  (adv),
      .d    (div_chain[k]),
      .q    (div_chain[k+1])
    );
  end

  // cordic chain, runs beside the square root
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    crp_cordic_cell u_cell (
      .clk(clk),
      .adv(adv),
      .idx(CORDIC_IDX_W'(k)),
      .d  (cordic_chain[k]),
      .q  (cordic_chain[k+1])
    );
  end

  // round half up to q3.13 and clamp
  logic signed [34:0] z_rnd;
  logic signed [17:0] z_q;
  logic signed [15:0] brg_nxt;
  logic signed [15:0] brg_dly_r [BRG_DELAY];

  always_comb begin
    z_rnd = cordic_chain[CORDIC_STAGES].z + 35'sd65536;
    z_q   = 18'(z_rnd >>> 17);
    if (z_q > BEARING_MAX) begin
      brg_nxt = 16'(BEARING_MAX);
    end else if (z_q < -BEARING_MAX) begin
      brg_nxt = 16'(-BEARING_MAX);
    end else begin
      brg_nxt = z_q[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      brg_dly_r[0] <= brg_nxt;
      for (int j = 1; j < BRG_DELAY; j++) begin
        brg_dly_r[j] <= brg_dly_r[j-1];
      end
    end
  end

  // output stage: sign, saturation and guard zeroing
  div_t               dv_end;
  logic signed [31:0] rate_nxt;
  logic               out_valid_r;
  logic [31:0]        range_r;
  logic signed [15:0] bearing_r;
  logic signed [31:0] rate_r;
  logic               guard_r;

  assign dv_end = div_chain[DIV_STAGES];

  always_comb begin
    if (dv_end.divisor == 32'd0) begin
      rate_nxt = '0;
    end else if (dv_end.side.neg) begin
      if (dv_end.ovf || dv_end.quo > 33'h080000000) begin
        rate_nxt = 32'sh80000000;
      end else begin
        rate_nxt = $signed(32'd0 - dv_end.quo[31:0]);
      end
    end else begin
      if (dv_end.ovf || dv_end.quo > 33'h07fffffff) begin
        rate_nxt = 32'sh7fffffff;
      end else begin
        rate_nxt = $signed(dv_end.quo[31:0]);
      end
    end
  end

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_end.side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      guard_r <= dv_end.side.guard;
      if (dv_end.side.guard) begin
        range_r   <= '0;
        bearing_r <= '0;
        rate_r    <= '0;
      end else begin
        range_r   <= dv_end.divisor;
        bearing_r <= brg_dly_r[BRG_DELAY-1];
        rate_r    <= rate_nxt;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_range_out  = range_r;
  assign out_bearing    = bearing_r;
  assign out_range_rate = rate_r;
  assign out_guard_hit  = guard_r;

  // a guarded item carries only zeros
  a_guard_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_guard_hit |->
      out_range_out == 32'd0 && out_range_rate == 32'sd0 && out_bearing == 16'sd0)
    else $error("guarded item has nonzero fields");

  // input holds exactly while a result waits
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall out of step with output");

  // bearing stays inside plus or minus pi
  a_bearing_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bearing <= 16'sd25736 && out_bearing >= -16'sd25736)
    else $error("bearing outside clamp");

endmodule
`default_nettype wire
